// File: rtl/ratpid_pkg.sv
// ----------------------------------------------------------------------------
// ratpid_pkg
// Types, constants and the finish-sequence microcode of the relay autotuner.
// ----------------------------------------------------------------------------
package ratpid_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int PC_BITS        = 6;

  localparam logic [31:0] K_AMP   = 32'd314159;     // pi scaled by 1e5
  localparam logic [31:0] K_KU    = 32'd204800000;  // 8 * 256 * 1e5
  localparam logic [31:0] K_P     = 32'd393216;     // 0.6 -> 6 * 65536 (over 10)
  localparam logic [31:0] K_TEN   = 32'd10;
  localparam logic [31:0] K_I     = 32'd786432000;  // 12 * 1000 * 65536
  localparam logic [31:0] K_D     = 32'd4915200;    // 75 * 65536
  localparam logic [31:0] K_MEGA  = 32'd1000000;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_STEP_POWER  = 2'd0,
    CFG_BAND        = 2'd1,
    CFG_TARGET_TEMP = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_LOAD, OP_MUL, OP_SAVE_T, OP_SUBCHK, OP_SAVE_AR, OP_SAVE_KN,
    OP_SAVE_N, OP_DIV, OP_SKIPZ, OP_END
  } op_t;

  typedef enum logic [3:0] {
    SEL_HS, SEL_LS, SEL_SP, SEL_KN, SEL_AR, SEL_LC, SEL_HC, SEL_N1,
    SEL_SPAN, SEL_K_AMP, SEL_K_KU, SEL_K_P, SEL_K_TEN, SEL_K_I, SEL_K_D,
    SEL_K_MEGA
  } sel_t;

  typedef enum logic [1:0] {
    G_P = 2'd0,
    G_I = 2'd1,
    G_D = 2'd2
  } gsel_t;

  typedef struct packed {
    op_t   op;
    sel_t  sel;
    gsel_t gsel;
  } uop_t;

  // first step of the derivative part, target of the zero-span skip
  localparam logic [PC_BITS-1:0] PC_D_PART = PC_BITS'(27);

  function automatic uop_t uop_rom(input logic [PC_BITS-1:0] pc);
    uop_t u;
    u = '{OP_END, SEL_HS, G_P};
    case (pc)
      6'd0:  u = '{OP_LOAD,    SEL_HS,     G_P};
      6'd1:  u = '{OP_MUL,     SEL_LC,     G_P};
      6'd2:  u = '{OP_SAVE_T,  SEL_HS,     G_P};
      6'd3:  u = '{OP_LOAD,    SEL_LS,     G_P};
      6'd4:  u = '{OP_MUL,     SEL_HC,     G_P};
      6'd5:  u = '{OP_SUBCHK,  SEL_HS,     G_P};
      6'd6:  u = '{OP_MUL,     SEL_K_AMP,  G_P};
      6'd7:  u = '{OP_SAVE_AR, SEL_HS,     G_P};
      6'd8:  u = '{OP_LOAD,    SEL_SP,     G_P};
      6'd9:  u = '{OP_MUL,     SEL_HC,     G_P};
      6'd10: u = '{OP_MUL,     SEL_LC,     G_P};
      6'd11: u = '{OP_MUL,     SEL_K_KU,   G_P};
      6'd12: u = '{OP_SAVE_KN, SEL_HS,     G_P};
      6'd13: u = '{OP_MUL,     SEL_K_P,    G_P};
      6'd14: u = '{OP_SAVE_N,  SEL_HS,     G_P};
      6'd15: u = '{OP_LOAD,    SEL_AR,     G_P};
      6'd16: u = '{OP_MUL,     SEL_K_TEN,  G_P};
      6'd17: u = '{OP_DIV,     SEL_HS,     G_P};
      6'd18: u = '{OP_SKIPZ,   SEL_HS,     G_I};
      6'd19: u = '{OP_LOAD,    SEL_KN,     G_I};
      6'd20: u = '{OP_MUL,     SEL_K_I,    G_I};
      6'd21: u = '{OP_MUL,     SEL_N1,     G_I};
      6'd22: u = '{OP_SAVE_N,  SEL_HS,     G_I};
      6'd23: u = '{OP_LOAD,    SEL_AR,     G_I};
      6'd24: u = '{OP_MUL,     SEL_K_TEN,  G_I};
      6'd25: u = '{OP_MUL,     SEL_SPAN,   G_I};
      6'd26: u = '{OP_DIV,     SEL_HS,     G_I};
      6'd27: u = '{OP_LOAD,    SEL_KN,     G_D};
      6'd28: u = '{OP_MUL,     SEL_K_D,    G_D};
      6'd29: u = '{OP_MUL,     SEL_SPAN,   G_D};
      6'd30: u = '{OP_SAVE_N,  SEL_HS,     G_D};
      6'd31: u = '{OP_LOAD,    SEL_AR,     G_D};
      6'd32: u = '{OP_MUL,     SEL_K_MEGA, G_D};
      6'd33: u = '{OP_MUL,     SEL_N1,     G_D};
      6'd34: u = '{OP_DIV,     SEL_HS,     G_D};
      default: u = '{OP_END,   SEL_HS,     G_P};
    endcase
    return u;
  endfunction

endpackage

// File: rtl/relay_autotune_pid_gains.sv
// ----------------------------------------------------------------------------
// relay_autotune_pid_gains
// Relay autotuner with hysteresis; derives Ziegler-Nichols P, I, D gains.
// ----------------------------------------------------------------------------
// Start, sample and unknown beats give their result beat from a register in the
// cycle after they are accepted. A finish beat runs a microcoded sequence of
// shift-add multiplies and saturating shift-subtract divides: each multiply is a
// fetch plus 32 steps and each divide a fetch, a range check and 32 steps. A
// finish runs 16 multiplies and 3 divides (fewer when the time span is zero,
// none when the counts already flag an error). The input is not ready while a
// finish runs or while a result beat is held without space.
module relay_autotune_pid_gains
  #(parameter int COUNT_BITS = ratpid_pkg::COUNT_BITS_DEF)
  (input  logic         clk,
   input  logic         rst,
   input  logic         s_tvalid,
   output logic         s_tready,
   input  logic [47:0]  s_tdata,   // temperature[15:0], timestamp_ms[47:16]
   input  logic [1:0]   s_tuser,   // kind[1:0]
   output logic         m_tvalid,
   input  logic         m_tready,
   output logic [103:0] m_tdata,   // power[6:0], gain_p[38:7], gain_i[70:39],
                                   // gain_d[102:71], zero pad
   output logic [1:0]   m_tuser,   // gains_valid[0], tune_error[1]
   input  logic         cfg_we,
   input  logic [1:0]   cfg_index,
   input  logic [15:0]  cfg_data);

  import ratpid_pkg::*;

  localparam int W = 2 * COUNT_BITS + 106;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_MUL, ST_DIV_CHK, ST_DIV, ST_DONE
  } state_t;

  state_t state;

  logic [6:0]  step_power;
  logic [9:0]  band;
  logic [15:0] target_temp;

  logic                  heater_on;
  logic [31:0]           low_sum, high_sum, first_time, last_time;
  logic [COUNT_BITS-1:0] low_count, high_count;

  logic [W-1:0] acc, mx, tmp, kn, ar, nn, dd;
  logic [31:0]  f, q, gp, gi, gd;
  logic [4:0]   cnt;
  logic [PC_BITS-1:0] pc;
  logic         err;

  logic         out_valid_g, out_err;
  logic [6:0]   out_power;
  logic [31:0]  out_gp, out_gi, out_gd;

  logic         accept, out_free;
  logic [15:0]  temp;
  logic [31:0]  ts;
  logic         below, above;
  uop_t         u;
  logic [W-1:0] opnd_w;
  logic [31:0]  opnd32;
  logic [31:0]  span;
  logic [COUNT_BITS-1:0] n1;
  logic [W-1:0] dsh;
  logic         ge;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign temp     = s_tdata[15:0];
  assign ts       = s_tdata[47:16];
  assign below    = ({1'b0, temp} + {7'd0, band}) < {1'b0, target_temp};
  assign above    = {1'b0, temp} > ({1'b0, target_temp} + {7'd0, band});
  assign span     = last_time - first_time;
  assign n1       = low_count - COUNT_BITS'(1);
  assign u        = uop_rom(pc);
  assign dsh      = dd >> 1;
  assign ge       = (state == ST_DIV) ? (nn >= dsh) : (nn >= dd);

  always_comb begin
    case (u.sel)
      SEL_HS:  opnd_w = W'(high_sum);
      SEL_LS:  opnd_w = W'(low_sum);
      SEL_SP:  opnd_w = W'(step_power);
      SEL_KN:  opnd_w = kn;
      SEL_AR:  opnd_w = ar;
      default: opnd_w = '0;
    endcase
    case (u.sel)
      SEL_LC:     opnd32 = 32'(low_count);
      SEL_HC:     opnd32 = 32'(high_count);
      SEL_N1:     opnd32 = 32'(n1);
      SEL_SPAN:   opnd32 = span;
      SEL_K_AMP:  opnd32 = K_AMP;
      SEL_K_KU:   opnd32 = K_KU;
      SEL_K_P:    opnd32 = K_P;
      SEL_K_TEN:  opnd32 = K_TEN;
      SEL_K_I:    opnd32 = K_I;
      SEL_K_D:    opnd32 = K_D;
      SEL_K_MEGA: opnd32 = K_MEGA;
      default:    opnd32 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step_power  <= 7'd100;
      band        <= 10'd51;
      target_temp <= 16'd23296;
      heater_on   <= 1'b0;
      low_sum     <= '0;
      high_sum    <= '0;
      low_count   <= '0;
      high_count  <= '0;
      first_time  <= '0;
      last_time   <= '0;
      m_tvalid    <= 1'b0;
      pc          <= '0;
      err         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_POWER:  step_power  <= cfg_data[6:0];
          CFG_BAND:        band        <= cfg_data[9:0];
          CFG_TARGET_TEMP: target_temp <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == KIND_FINISH) begin
              gp <= '0;
              gi <= '0;
              gd <= '0;
              pc <= '0;
              if (low_count < COUNT_BITS'(2) || high_count == '0) begin
                err   <= 1'b1;
                state <= ST_DONE;
              end else begin
                err   <= 1'b0;
                state <= ST_FETCH;
              end
            end else begin
              logic h;
              h = heater_on;
              if (s_tuser == KIND_START) begin
                low_sum    <= '0;
                high_sum   <= '0;
                low_count  <= '0;
                high_count <= '0;
                first_time <= '0;
                last_time  <= '0;
              end else if (s_tuser == KIND_SAMPLE) begin
                if (below) begin
                  if (!heater_on && low_count != CMAX) begin
                    if (low_count == '0) first_time <= ts;
                    last_time <= ts;
                    low_count <= low_count + COUNT_BITS'(1);
                    low_sum   <= low_sum + 32'(temp);
                  end
                  h = 1'b1;
                end else if (above) begin
                  if (heater_on && high_count != CMAX) begin
                    high_count <= high_count + COUNT_BITS'(1);
                    high_sum   <= high_sum + 32'(temp);
                  end
                  h = 1'b0;
                end
              end
              heater_on   <= h;
              m_tvalid    <= 1'b1;
              out_power   <= h ? step_power : 7'd0;
              out_valid_g <= 1'b0;
              out_err     <= 1'b0;
              out_gp      <= '0;
              out_gi      <= '0;
              out_gd      <= '0;
            end
          end
        end

        ST_FETCH: begin
          // a divide keeps its step so gsel stays valid until it ends
          if (u.op != OP_DIV) pc <= pc + PC_BITS'(1);
          case (u.op)
            OP_LOAD:    acc <= opnd_w;
            OP_MUL: begin
              mx    <= acc;
              acc   <= '0;
              f     <= opnd32;
              cnt   <= '0;
              state <= ST_MUL;
            end
            OP_SAVE_T:  tmp <= acc;
            OP_SUBCHK: begin
              if (tmp > acc) acc <= tmp - acc;
              else begin
                err   <= 1'b1;
                state <= ST_DONE;
              end
            end
            OP_SAVE_AR: ar <= acc;
            OP_SAVE_KN: kn <= acc;
            OP_SAVE_N:  nn <= acc;
            OP_DIV: begin
              dd    <= acc << 32;
              state <= ST_DIV_CHK;
            end
            OP_SKIPZ: begin
              if (span == '0) begin
                gi <= '1;
                pc <= PC_D_PART;
              end
            end
            default: state <= ST_DONE;
          endcase
        end

        ST_MUL: begin
          // shift-add, factor MSB first
          acc <= (acc << 1) + (f[31] ? mx : '0);
          f   <= f << 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= ST_FETCH;
        end

        ST_DIV_CHK: begin
          q   <= '0;
          cnt <= '0;
          if (ge) begin
            case (u.gsel)
              G_P:     gp <= '1;
              G_I:     gi <= '1;
              default: gd <= '1;
            endcase
            pc    <= pc + PC_BITS'(1);
            state <= ST_FETCH;
          end else begin
            state <= ST_DIV;
          end
        end

        ST_DIV: begin
          logic [31:0] qn;
          qn = {q[30:0], ge};
          dd <= dsh;
          if (ge) nn <= nn - dsh;
          q   <= qn;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            case (u.gsel)
              G_P:     gp <= qn;
              G_I:     gi <= qn;
              default: gd <= qn;
            endcase
            pc    <= pc + PC_BITS'(1);
            state <= ST_FETCH;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            m_tvalid    <= 1'b1;
            out_power   <= heater_on ? step_power : 7'd0;
            out_valid_g <= !err;
            out_err     <= err;
            out_gp      <= err ? '0 : gp;
            out_gi      <= err ? '0 : gi;
            out_gd      <= err ? '0 : gd;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {1'b0, out_gd, out_gi, out_gp, out_power};
  assign m_tuser = {out_err, out_valid_g};

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready)
    else $error("input ready while a finish runs");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("gains_valid and tune_error both set");

  a_gains_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[102:7] == '0))
    else $error("nonzero gains on a result without valid gains");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == KIND_FINISH) |=> !s_tready)
    else $error("ready right after a finish beat");

endmodule
